// ----- rtl/core/igc_trp_pkg.sv -----
package igc_trp_pkg;

  // parser phases
  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_B_DIG  = 4'd1,
    PH_B_SCAN = 4'd2,
    PH_B_LF   = 4'd3,
    PH_H_LIT  = 4'd4,
    PH_H_DIG  = 4'd5,
    PH_H_CR   = 4'd6,
    PH_H_LF   = 4'd7,
    PH_OK     = 4'd8,
    PH_FAIL   = 4'd9
  } phase_t;

  // characters
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [2:0] HDR_LEN   = 3'd5;
  localparam logic [2:0] DIG_COUNT = 3'd6;

  // year offset: two-digit year is counted from 2000
  localparam logic [7:0] YEAR_BIAS = 8'd100;

  // one result item
  typedef struct packed {
    logic              line_ok;
    logic [6:0]        hour;
    logic [6:0]        minute;
    logic [6:0]        second;
    logic [6:0]        day_of_month;
    logic signed [7:0] month_index;
    logic [7:0]        years_since_1900;
  } result_t;

  // header text "HFDTE" by position
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h46;
      3'd2:    c = 8'h44;
      3'd3:    c = 8'h54;
      3'd4:    c = 8'h45;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/igc_trp_parser.sv -----
module igc_trp_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  logic [7:0]             line_byte,
  input  logic                   end_of_line,
  output igc_trp_pkg::result_t   result
);
  import igc_trp_pkg::*;

  phase_t      phase_r, phase_nxt, ph;
  logic [2:0]  pos_r, pos_nxt, pos;
  logic [20:0] accum_r, accum_nxt, acc;
  logic [20:0] time_r, time_nxt, tm;
  logic [20:0] date_r, date_nxt, dt;

  logic        is_digit;
  logic        dig_ok;
  logic [1:0]  fld;
  logic [6:0]  cur;
  logic [10:0] prod;
  logic [6:0]  pair;
  logic [20:0] acc_dig;

  // digit accumulation into the selected 7-bit pair
  assign is_digit = (line_byte >= CH_ZERO) && (line_byte <= CH_NINE);
  assign fld      = pos_r[2:1];
  assign dig_ok   = is_digit && (fld != 2'd3);
  assign prod     = {4'b0, cur} * 11'd10 + {7'b0, line_byte[3:0]};
  assign pair     = pos_r[0] ? prod[6:0] : {3'b0, line_byte[3:0]};

  always_comb begin
    cur     = 7'd0;
    acc_dig = accum_r;
    case (fld)
      2'd0: begin
        cur           = accum_r[6:0];
        acc_dig[6:0]  = pair;
      end
      2'd1: begin
        cur           = accum_r[13:7];
        acc_dig[13:7] = pair;
      end
      2'd2: begin
        cur            = accum_r[20:14];
        acc_dig[20:14] = pair;
      end
      default: begin
        cur     = 7'd0;
        acc_dig = accum_r;
      end
    endcase
  end

  // one step of the line recognizer
  always_comb begin
    ph  = phase_r;
    pos = pos_r;
    acc = accum_r;
    tm  = time_r;
    dt  = date_r;
    if (phase_r != PH_OK && phase_r != PH_FAIL && line_byte == CH_NUL) begin
      ph = PH_FAIL;
    end else begin
      case (phase_r)
        PH_START: begin
          pos = 3'd0;
          acc = '0;
          if (line_byte == CH_B) begin
            ph = PH_B_DIG;
          end else if (line_byte == CH_H) begin
            ph  = PH_H_LIT;
            pos = 3'd1;
          end else begin
            ph = PH_FAIL;
          end
        end
        PH_B_DIG, PH_H_DIG: begin
          if (!dig_ok) begin
            ph = PH_FAIL;
          end else begin
            acc = acc_dig;
            pos = pos_r + 3'd1;
            if (pos >= DIG_COUNT) begin
              ph = (phase_r == PH_B_DIG) ? PH_B_SCAN : PH_H_CR;
            end
          end
        end
        PH_B_SCAN: begin
          if (line_byte == CH_CR) ph = PH_B_LF;
        end
        PH_B_LF: begin
          if (line_byte == CH_LF) begin
            tm = accum_r;
            ph = PH_OK;
          end else begin
            ph = PH_FAIL;
          end
        end
        PH_H_LIT: begin
          if (pos_r < HDR_LEN && line_byte == hdr_char(pos_r)) begin
            pos = pos_r + 3'd1;
            if (pos >= HDR_LEN) begin
              ph  = PH_H_DIG;
              pos = 3'd0;
            end
          end else begin
            ph = PH_FAIL;
          end
        end
        PH_H_CR: begin
          ph = (line_byte == CH_CR) ? PH_H_LF : PH_FAIL;
        end
        PH_H_LF: begin
          if (line_byte == CH_LF) begin
            dt = accum_r;
            ph = PH_OK;
          end else begin
            ph = PH_FAIL;
          end
        end
        PH_OK: begin
          ph = PH_OK;
        end
        default: begin
          ph = PH_FAIL;
        end
      endcase
    end
  end

  // next state, rearmed at end of line
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    accum_nxt = accum_r;
    time_nxt  = time_r;
    date_nxt  = date_r;
    if (fire) begin
      time_nxt = tm;
      date_nxt = dt;
      if (end_of_line) begin
        phase_nxt = PH_START;
        pos_nxt   = 3'd0;
        accum_nxt = '0;
      end else begin
        phase_nxt = ph;
        pos_nxt   = pos;
        accum_nxt = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      pos_r   <= 3'd0;
      accum_r <= '0;
      time_r  <= '0;
      date_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      accum_r <= accum_nxt;
      time_r  <= time_nxt;
      date_r  <= date_nxt;
    end
  end

  // result fields from the updated held time and date
  always_comb begin
    result.line_ok          = (ph == PH_OK);
    result.hour             = tm[6:0];
    result.minute           = tm[13:7];
    result.second           = tm[20:14];
    result.day_of_month     = dt[6:0];
    result.month_index      = $signed({1'b0, dt[13:7]} - 8'd1);
    result.years_since_1900 = {1'b0, dt[20:14]} + YEAR_BIAS;
  end

endmodule

// ----- rtl/core/igc_time_record_parser_top.sv -----
// latency: a result is valid in the cycle after its end-of-line byte leaves the input register
// throughput: one byte per cycle; a byte in the input register that is not the last
// of a line never waits there
// an end-of-line byte waits in the input register only while a result is held and stalled
// reset: synchronous active-low rst_n clears the parser to start of line,
// the held time and date to zero and both valid flags
module igc_time_record_parser_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_line_byte,
  input  logic              in_end_of_line,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_line_ok,
  output logic [6:0]        out_hour,
  output logic [6:0]        out_minute,
  output logic [6:0]        out_second,
  output logic [6:0]        out_day_of_month,
  output logic signed [7:0] out_month_index,
  output logic [7:0]        out_years_since_1900
);
  import igc_trp_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_eol_r;
  logic       in_fire;
  logic       s1_fire;
  logic       out_valid_r, out_valid_nxt;
  result_t    res;
  result_t    out_res_r;

  // input register advances unless a finished line waits on a full, stalled result slot
  assign s1_fire  = s1_valid_r && (!s1_eol_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_line_byte;
      s1_eol_r  <= in_end_of_line;
    end
  end

  igc_trp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_fire),
    .line_byte   (s1_byte_r),
    .end_of_line (s1_eol_r),
    .result      (res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_eol_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_eol_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_line_ok          = out_res_r.line_ok;
  assign out_hour             = out_res_r.hour;
  assign out_minute           = out_res_r.minute;
  assign out_second           = out_res_r.second;
  assign out_day_of_month     = out_res_r.day_of_month;
  assign out_month_index      = out_res_r.month_index;
  assign out_years_since_1900 = out_res_r.years_since_1900;

  // only a waiting end-of-line byte can hold off the input
  a_stall_only_eol: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_eol_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked end-of-line byte");

  // a new result appears only after an end-of-line byte was processed
  a_result_from_eol: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_eol_r))
    else $error("result without an end-of-line transfer");

  // a processed end-of-line byte always lands in the result register
  a_eol_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_eol_r) |=> out_valid_r)
    else $error("end-of-line byte lost");

endmodule
